/* hw/rtl/assert_macros.svh */
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition holds on every rising aclk edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

`endif

/* hw/rtl/hppa_pkg.sv */
// Package with widths, codes and defaults of the huge page pool allocator.
package hppa_pkg;

    localparam int FUNC_W  = 2;
    localparam int CNT_W   = 11;
    localparam int FADDR_W = 52;
    localparam int OPS_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 152;

    localparam int DEF_DEPTH_2M  = 1024;
    localparam int DEF_DEPTH_1G  = 16;
    localparam int DEF_ADDR_BITS = 52;

    localparam int SH_2M = 21;
    localparam int SH_1G = 30;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam func_t FN_RESERVE = 2'd0;
    localparam func_t FN_ALLOC   = 2'd1;
    localparam func_t FN_FREE    = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_UNSUP = 2'd1;
    localparam status_t ST_NONE  = 2'd2;
    localparam status_t ST_ALIGN = 2'd3;

    localparam cfg_idx_t REG_SUPPORT_2M = 2'd0;
    localparam cfg_idx_t REG_SUPPORT_1G = 2'd1;
    localparam cfg_idx_t REG_BASE_2M    = 2'd2;
    localparam cfg_idx_t REG_BASE_1G    = 2'd3;

    localparam logic [FADDR_W-1:0] BASE_2M_RST = 52'h0_0001_0000_0000;
    localparam logic [FADDR_W-1:0] BASE_1G_RST = 52'h0_0002_0000_0000;

endpackage

/* hw/rtl/hppa_ram.sv */
// Generic simple dual-port RAM with registered read.
module hppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/huge_page_pool_allocator_unit.sv */
// Top level of the huge page pool allocator: two page pools kept in RAM.
// Rejected requests go from the accepted item straight to the response state.
// Reserve: one table entry written per cycle, for min(count, free slots) entries.
// Allocate and free: one table read per cycle until a hit, which is written back.
// One item at a time; a new item is taken while the last result waits on m_tready.
// Reset clears counters and fill counts, restores config; unfilled entries are never used.
`include "assert_macros.svh"

module huge_page_pool_allocator_unit #(
    parameter int DEPTH_2M  = hppa_pkg::DEF_DEPTH_2M,
    parameter int DEPTH_1G  = hppa_pkg::DEF_DEPTH_1G,
    parameter int ADDR_BITS = hppa_pkg::DEF_ADDR_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  hppa_pkg::cfg_idx_t               cfg_index,
    input  logic [hppa_pkg::FADDR_W-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // count[10:0], phys_addr[62:11], zero pad[63]
    input  logic [hppa_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[1:0], pool_sel[2]
    input  logic [hppa_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], page_addr[53:2], reserved_count[64:54], total_pages[75:65],
    // free_pages[86:76], alloc_ops[118:87], free_ops[150:119], zero pad[151]
    output logic [hppa_pkg::M_TDATA_W-1:0]   m_tdata
);
    import hppa_pkg::*;

    localparam int DMAX = (DEPTH_2M > DEPTH_1G) ? DEPTH_2M : DEPTH_1G;
    localparam int CW   = $clog2(DMAX + 1);
    localparam int E2_W = $clog2(DEPTH_2M + 1);
    localparam int E1_W = $clog2(DEPTH_1G + 1);
    localparam int I2_W = $clog2(DEPTH_2M);
    localparam int I1_W = $clog2(DEPTH_1G);
    localparam int AW   = ADDR_BITS;
    localparam int WW   = (AW > FADDR_W) ? AW : FADDR_W;
    localparam int RW   = AW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RSV  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 pool_reg, pool_next;
    logic                 is_free_reg, is_free_next;
    logic [FADDR_W-1:0]   phys_reg, phys_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [CNT_W-1:0]     added_reg, added_next;
    status_t              st_reg, st_next;
    logic [FADDR_W-1:0]   pa_reg, pa_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [CW-1:0]        pend_idx_reg, pend_idx_next;

    logic [E2_W-1:0]      ent2_reg, ent2_next, fl2_reg, fl2_next;
    logic [E1_W-1:0]      ent1_reg, ent1_next, fl1_reg, fl1_next;
    logic [OPS_W-1:0]     ao2_reg, ao2_next, fo2_reg, fo2_next;
    logic [OPS_W-1:0]     ao1_reg, ao1_next, fo1_reg, fo1_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 sup2_reg, sup1_reg;
    logic [FADDR_W-1:0]   base2_reg, base1_reg;

    logic                 ram_we;
    logic [CW-1:0]        ram_waddr;
    logic [RW-1:0]        ram_wdata;
    logic [RW-1:0]        rdata2, rdata1, rdata;
    logic                 rd_used;
    logic [AW-1:0]        rd_addr;

    func_t                in_func;
    logic                 in_sel;
    logic [CNT_W-1:0]     in_count;
    logic [FADDR_W-1:0]   in_phys;
    logic                 accept;
    logic                 in_ok;
    logic [CW-1:0]        in_ent, in_depth;
    logic [FADDR_W-1:0]   in_base, in_mask;
    logic [CW-1:0]        sel_ent, sel_depth;
    logic [AW-1:0]        sel_page;
    logic                 hit;
    logic                 inc_ent, inc_fl, dec_fl, inc_ao, inc_fo;
    logic [CNT_W-1:0]     out_total, out_free;
    logic [OPS_W-1:0]     out_ao, out_fo;

    assign in_count = s_tdata[CNT_W-1:0];
    assign in_phys  = s_tdata[CNT_W+FADDR_W-1:CNT_W];
    assign in_func  = s_tuser[FUNC_W-1:0];
    assign in_sel   = s_tuser[FUNC_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_ok    = sup2_reg && (!in_sel || sup1_reg);
    assign in_ent   = in_sel ? CW'(ent1_reg) : CW'(ent2_reg);
    assign in_depth = in_sel ? CW'(DEPTH_1G) : CW'(DEPTH_2M);
    assign in_base  = in_sel ? base1_reg : base2_reg;
    assign in_mask  = in_sel ? ((FADDR_W'(1) << SH_1G) - FADDR_W'(1))
                             : ((FADDR_W'(1) << SH_2M) - FADDR_W'(1));

    assign sel_ent   = pool_reg ? CW'(ent1_reg) : CW'(ent2_reg);
    assign sel_depth = pool_reg ? CW'(DEPTH_1G) : CW'(DEPTH_2M);
    assign sel_page  = pool_reg ? (AW'(1) << SH_1G) : (AW'(1) << SH_2M);

    assign rdata   = pool_reg ? rdata1 : rdata2;
    assign rd_used = rdata[AW];
    assign rd_addr = rdata[AW-1:0];
    assign hit = pend_vld_reg && (is_free_reg ? (rd_used && (WW'(rd_addr) == WW'(phys_reg)))
                                              : !rd_used);

    assign out_total = pool_reg ? CNT_W'(ent1_reg) : CNT_W'(ent2_reg);
    assign out_free  = pool_reg ? CNT_W'(fl1_reg) : CNT_W'(fl2_reg);
    assign out_ao    = pool_reg ? ao1_reg : ao2_reg;
    assign out_fo    = pool_reg ? fo1_reg : fo2_reg;

    hppa_ram #(.WIDTH(RW), .DEPTH(DEPTH_2M)) u_ram_2m (
        .aclk  (aclk),
        .we    (ram_we && !pool_reg),
        .waddr (ram_waddr[I2_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[I2_W-1:0]),
        .rdata (rdata2)
    );

    hppa_ram #(.WIDTH(RW), .DEPTH(DEPTH_1G)) u_ram_1g (
        .aclk  (aclk),
        .we    (ram_we && pool_reg),
        .waddr (ram_waddr[I1_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[I1_W-1:0]),
        .rdata (rdata1)
    );

    always_comb begin
        state_next    = state_reg;
        pool_next     = pool_reg;
        is_free_next  = is_free_reg;
        phys_next     = phys_reg;
        left_next     = left_reg;
        addr_next     = addr_reg;
        added_next    = added_reg;
        st_next       = st_reg;
        pa_next       = pa_reg;
        rd_idx_next   = rd_idx_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = sel_ent;
        ram_wdata     = {1'b0, addr_reg};
        inc_ent       = 1'b0;
        inc_fl        = 1'b0;
        dec_fl        = 1'b0;
        inc_ao        = 1'b0;
        inc_fo        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pool_next    = in_sel;
                    is_free_next = (in_func == FN_FREE);
                    phys_next    = in_phys;
                    left_next    = in_count;
                    addr_next    = AW'(in_base);
                    added_next   = '0;
                    pa_next      = '0;
                    rd_idx_next  = '0;
                    st_next      = ST_UNSUP;
                    state_next   = S_RESP;
                    if (in_ok) begin
                        case (in_func)
                            FN_RESERVE: begin
                                if (in_count != '0) begin
                                    if ((in_base & in_mask) != '0) begin
                                        st_next = (in_ent == in_depth) ? ST_OK : ST_ALIGN;
                                    end else begin
                                        st_next    = ST_OK;
                                        state_next = S_RSV;
                                    end
                                end
                            end
                            FN_ALLOC: begin
                                st_next = ST_NONE;
                                if (in_ent != '0) begin
                                    state_next = S_SCAN;
                                end
                            end
                            FN_FREE: begin
                                if ((in_phys & in_mask) != '0) begin
                                    st_next = ST_ALIGN;
                                end else begin
                                    st_next = ST_NONE;
                                    if (in_ent != '0) begin
                                        state_next = S_SCAN;
                                    end
                                end
                            end
                            default: begin
                                st_next = ST_UNSUP;
                            end
                        endcase
                    end
                end
            end
            S_RSV: begin
                if (left_reg == '0 || sel_ent == sel_depth) begin
                    state_next = S_RESP;
                end else begin
                    ram_we     = 1'b1;
                    inc_ent    = 1'b1;
                    inc_fl     = 1'b1;
                    added_next = added_reg + CNT_W'(1);
                    left_next  = left_reg - CNT_W'(1);
                    addr_next  = addr_reg + sel_page;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    ram_we     = 1'b1;
                    ram_waddr  = pend_idx_reg;
                    ram_wdata  = {!rd_used, rd_addr};
                    st_next    = ST_OK;
                    state_next = S_RESP;
                    if (is_free_reg) begin
                        inc_fl = 1'b1;
                        inc_fo = 1'b1;
                    end else begin
                        dec_fl  = 1'b1;
                        inc_ao  = 1'b1;
                        pa_next = FADDR_W'(rd_addr);
                    end
                end else if (!pend_vld_reg && rd_idx_reg == sel_ent) begin
                    st_next    = ST_NONE;
                    state_next = S_RESP;
                end else if (rd_idx_reg < sel_ent) begin
                    pend_vld_next = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, out_fo, out_ao, out_free, out_total,
                                     added_reg, pa_reg, st_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ent2_next = ent2_reg;
        ent1_next = ent1_reg;
        fl2_next  = fl2_reg;
        fl1_next  = fl1_reg;
        ao2_next  = ao2_reg;
        ao1_next  = ao1_reg;
        fo2_next  = fo2_reg;
        fo1_next  = fo1_reg;
        if (pool_reg) begin
            if (inc_ent) ent1_next = ent1_reg + E1_W'(1);
            if (inc_fl)  fl1_next  = fl1_reg + E1_W'(1);
            if (dec_fl)  fl1_next  = fl1_reg - E1_W'(1);
            if (inc_ao)  ao1_next  = ao1_reg + OPS_W'(1);
            if (inc_fo)  fo1_next  = fo1_reg + OPS_W'(1);
        end else begin
            if (inc_ent) ent2_next = ent2_reg + E2_W'(1);
            if (inc_fl)  fl2_next  = fl2_reg + E2_W'(1);
            if (dec_fl)  fl2_next  = fl2_reg - E2_W'(1);
            if (inc_ao)  ao2_next  = ao2_reg + OPS_W'(1);
            if (inc_fo)  fo2_next  = fo2_reg + OPS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            ent2_reg     <= '0;
            ent1_reg     <= '0;
            fl2_reg      <= '0;
            fl1_reg      <= '0;
            ao2_reg      <= '0;
            ao1_reg      <= '0;
            fo2_reg      <= '0;
            fo1_reg      <= '0;
            sup2_reg     <= 1'b1;
            sup1_reg     <= 1'b1;
            base2_reg    <= BASE_2M_RST;
            base1_reg    <= BASE_1G_RST;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            ent2_reg     <= ent2_next;
            ent1_reg     <= ent1_next;
            fl2_reg      <= fl2_next;
            fl1_reg      <= fl1_next;
            ao2_reg      <= ao2_next;
            ao1_reg      <= ao1_next;
            fo2_reg      <= fo2_next;
            fo1_reg      <= fo1_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SUPPORT_2M: sup2_reg  <= cfg_wdata[0];
                    REG_SUPPORT_1G: sup1_reg  <= cfg_wdata[0];
                    REG_BASE_2M:    base2_reg <= cfg_wdata;
                    REG_BASE_1G:    base1_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pool_reg     <= pool_next;
        is_free_reg  <= is_free_next;
        phys_reg     <= phys_next;
        left_reg     <= left_next;
        addr_reg     <= addr_next;
        added_reg    <= added_next;
        st_reg       <= st_next;
        pa_reg       <= pa_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        m_tdata_reg  <= m_tdata_next;
    end

    `ASSERT_ALWAYS(a_fill_2m, ent2_reg <= E2_W'(DEPTH_2M) && fl2_reg <= ent2_reg,
                   "2M pool count out of range")
    `ASSERT_ALWAYS(a_fill_1g, ent1_reg <= E1_W'(DEPTH_1G) && fl1_reg <= ent1_reg,
                   "1G pool count out of range")
    `ASSERT_CLK(a_pend_idx,
                pend_vld_reg |-> (state_reg == S_SCAN && pend_idx_reg < sel_ent),
                "scan read beyond fill count")
    `ASSERT_CLK(a_hit_ends, (state_reg == S_SCAN && ram_we) |=> (state_reg == S_RESP),
                "scan continued after write-back")

endmodule

/* tb/sv/tb_huge_page_pool_allocator_unit.sv */
// Testbench for the huge page pool allocator: shadow pool model, stream drivers, reply checks.
`timescale 1ns / 100ps

module tb_huge_page_pool_allocator_unit;
    import hppa_pkg::*;

    localparam func_t FN_UNKNOWN = 2'd3;

    typedef struct {
        status_t      status;
        logic [51:0]  page_addr;
        logic [10:0]  reserved;
        logic [10:0]  total;
        logic [10:0]  free;
        logic [31:0]  alloc_ops;
        logic [31:0]  free_ops;
    } reply_t;

    class page_pool_shadow;
        bit          sup_2m;
        bit          sup_1g;
        logic [51:0] base [2];
        logic [51:0] page_tab [2][1024];
        bit          busy [2][1024];
        int unsigned entries [2];
        int unsigned free_left [2];
        logic [31:0] alloc_ops [2];
        logic [31:0] free_ops [2];
        reply_t      replies_due [$];
        int unsigned errors;
        int unsigned replies_seen;
        int unsigned req_kind [4];

        function new();
            sup_2m = 1;
            sup_1g = 1;
            base[0] = BASE_2M_RST;
            base[1] = BASE_1G_RST;
            for (int p = 0; p < 2; p++) begin
                entries[p] = 0;
                free_left[p] = 0;
                alloc_ops[p] = '0;
                free_ops[p] = '0;
                for (int i = 0; i < 1024; i++) busy[p][i] = 0;
            end
            errors = 0;
            replies_seen = 0;
            for (int k = 0; k < 4; k++) req_kind[k] = 0;
        endfunction

        function int unsigned depth_of(bit pool);
            return pool ? DEF_DEPTH_1G : DEF_DEPTH_2M;
        endfunction

        function logic [63:0] page_of(bit pool);
            return 64'd1 << (pool ? SH_1G : SH_2M);
        endfunction

        function void set_reg(cfg_idx_t idx, logic [51:0] val);
            case (idx)
                REG_SUPPORT_2M: sup_2m = val[0];
                REG_SUPPORT_1G: sup_1g = val[0];
                REG_BASE_2M:    base[0] = val;
                REG_BASE_1G:    base[1] = val;
                default: ;
            endcase
        endfunction

        function void take_request(func_t fn, bit pool, logic [10:0] cnt, logic [51:0] pa);
            reply_t      r;
            logic [63:0] pg;
            logic [51:0] a;
            bit          mis;
            bit          hit;
            int unsigned i;
            pg = page_of(pool);
            r.status = ST_UNSUP;
            r.page_addr = '0;
            r.reserved = '0;
            mis = 0;
            hit = 0;
            req_kind[fn]++;
            if (sup_2m && (!pool || sup_1g)) begin
                case (fn)
                    FN_RESERVE: begin
                        if (cnt != 0) begin
                            for (i = 0; i < cnt && entries[pool] < depth_of(pool); i++) begin
                                a = 52'(base[pool] + 64'(i) * pg);
                                if ((a & 52'(pg - 1)) != 0) begin
                                    mis = 1;
                                end else begin
                                    page_tab[pool][entries[pool]] = a;
                                    busy[pool][entries[pool]] = 0;
                                    entries[pool]++;
                                    free_left[pool]++;
                                    r.reserved = r.reserved + 1;
                                end
                            end
                            r.status = (r.reserved == 0 && mis) ? ST_ALIGN : ST_OK;
                        end
                    end
                    FN_ALLOC: begin
                        r.status = ST_NONE;
                        for (i = 0; i < entries[pool] && !hit; i++) begin
                            if (!busy[pool][i]) begin
                                hit = 1;
                                busy[pool][i] = 1;
                                free_left[pool]--;
                                alloc_ops[pool]++;
                                r.status = ST_OK;
                                r.page_addr = page_tab[pool][i];
                            end
                        end
                    end
                    FN_FREE: begin
                        if ((pa & 52'(pg - 1)) != 0) begin
                            r.status = ST_ALIGN;
                        end else begin
                            r.status = ST_NONE;
                            for (i = 0; i < entries[pool] && !hit; i++) begin
                                if (busy[pool][i] && page_tab[pool][i] == pa) begin
                                    hit = 1;
                                    busy[pool][i] = 0;
                                    free_left[pool]++;
                                    free_ops[pool]++;
                                    r.status = ST_OK;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.total = 11'(entries[pool]);
            r.free = 11'(free_left[pool]);
            r.alloc_ops = alloc_ops[pool];
            r.free_ops = free_ops[pool];
            replies_due.push_back(r);
        endfunction

        function logic [51:0] pick_busy_page(bit pool);
            int unsigned n;
            int unsigned k;
            logic [63:0] raw;
            n = 0;
            for (int i = 0; i < entries[pool]; i++) if (busy[pool][i]) n++;
            if (n == 0) begin
                raw = {$urandom, $urandom};
                return raw[51:0] & ~52'(page_of(pool) - 1);
            end
            k = $urandom_range(n - 1);
            for (int i = 0; i < entries[pool]; i++) begin
                if (busy[pool][i]) begin
                    if (k == 0) return page_tab[pool][i];
                    k--;
                end
            end
            return '0;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch in reply %0d, %s: expected %0h, got %0h",
                             replies_seen, name, want, got);
            end
        endfunction

        function void match_reply(logic [M_TDATA_W-1:0] d);
            reply_t w;
            replies_seen++;
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("reply %0d arrived with no request pending: %0h", replies_seen, d);
                return;
            end
            w = replies_due.pop_front();
            check_field("status", w.status, d[1:0]);
            check_field("page_addr", w.page_addr, d[53:2]);
            check_field("reserved_count", w.reserved, d[64:54]);
            check_field("total_pages", w.total, d[75:65]);
            check_field("free_pages", w.free, d[86:76]);
            check_field("alloc_ops", w.alloc_ops, d[118:87]);
            check_field("free_ops", w.free_ops, d[150:119]);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    cfg_idx_t               cfg_index;
    logic [FADDR_W-1:0]     cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    page_pool_shadow ledger;
    bit              calm;
    int unsigned     settings;

    huge_page_pool_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready = calm || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.match_reply(m_tdata);
    end

    function automatic logic [51:0] rand_addr();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[51:0];
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [51:0] val);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = val;
        ledger.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic write_all(bit s2m, bit s1g, logic [51:0] b2m, logic [51:0] b1g);
        write_reg(REG_SUPPORT_2M, {51'd0, s2m});
        write_reg(REG_SUPPORT_1G, {51'd0, s1g});
        write_reg(REG_BASE_2M, b2m);
        write_reg(REG_BASE_1G, b1g);
        settings++;
    endtask

    task automatic send_request(func_t fn, bit pool, logic [10:0] cnt, logic [51:0] pa);
        while (!calm && $urandom_range(99) < 32) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {1'b0, pa, cnt};
        s_tuser = {pool, fn};
        do @(posedge aclk); while (!s_tready);
        ledger.take_request(fn, pool, cnt, pa);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic wait_idle();
        while (ledger.replies_due.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [51:0] rand_base(bit pool);
        int unsigned roll;
        logic [51:0] lowmask;
        lowmask = pool ? 52'h3FFF_FFFF : 52'h1F_FFFF;
        roll = $urandom_range(99);
        if (roll < 60) return rand_addr() & ~lowmask;
        if (roll < 75) return '0;
        if (roll < 85) return ~lowmask;
        return rand_addr() | 52'd1;
    endfunction

    task automatic random_request();
        func_t       fn;
        bit          pool;
        logic [10:0] cnt;
        logic [51:0] pa;
        int unsigned roll;
        int unsigned sz;
        pool = $urandom_range(99) < 40;
        cnt = 11'($urandom_range(2047));
        pa = rand_addr();
        roll = $urandom_range(99);
        if (roll < 25) begin
            fn = FN_RESERVE;
            sz = $urandom_range(99);
            if (sz < 70) cnt = 11'($urandom_range(1, 8));
            else if (sz < 90) cnt = 11'($urandom_range(9, 64));
            else if (sz < 97) cnt = '0;
            else cnt = 11'($urandom_range(1, 1024));
        end else if (roll < 60) begin
            fn = FN_ALLOC;
        end else if (roll < 85) begin
            fn = FN_FREE;
            pa = ledger.pick_busy_page(pool);
        end else if (roll < 92) begin
            fn = FN_FREE;
        end else if (roll < 97) begin
            fn = FN_FREE;
            pa = pa & ~52'(ledger.page_of(pool) - 1);
        end else begin
            fn = FN_UNKNOWN;
        end
        send_request(fn, pool, cnt, pa);
    endtask

    initial begin
        ledger = new();
        calm = 0;
        settings = 0;
        aclk = 0;
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_index = REG_SUPPORT_2M;
        cfg_wdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // 2 MiB pool from address zero, 1 GiB base misaligned
        write_all(1, 1, 52'd0, 52'h3);
        send_request(FN_RESERVE, 0, 11'd2, '0);
        send_request(FN_ALLOC, 0, '0, '0);
        send_request(FN_ALLOC, 0, '0, '0);
        send_request(FN_ALLOC, 0, '0, '0);
        send_request(FN_FREE, 0, '0, 52'd0);
        send_request(FN_FREE, 0, '0, 52'hF_FFFF_FFFF_FFFF);
        send_request(FN_FREE, 0, '0, 52'h40_0000);
        send_request(FN_RESERVE, 0, 11'd0, '0);
        send_request(FN_UNKNOWN, 0, 11'h7FF, 52'hF_FFFF_FFFF_FFFF);
        send_request(FN_RESERVE, 1, 11'd4, '0);
        wait_idle();

        // bases near the top of the address space, so reserves wrap
        write_all(1, 1, 52'hF_FFFF_FFC0_0000, 52'hF_FFFF_8000_0000);
        send_request(FN_RESERVE, 1, 11'd1024, '0);
        send_request(FN_RESERVE, 1, 11'd1, '0);
        send_request(FN_ALLOC, 1, '0, '0);
        send_request(FN_FREE, 1, '0, 52'h20_0000);
        send_request(FN_FREE, 1, '0, 52'h4000_0000);
        send_request(FN_FREE, 1, '0, 52'hF_FFFF_8000_0000);
        send_request(FN_RESERVE, 0, 11'd4, '0);
        wait_idle();

        write_all(1, 0, 52'hF_FFFF_FFC0_0000, 52'hF_FFFF_8000_0000);
        send_request(FN_ALLOC, 1, '0, '0);
        send_request(FN_ALLOC, 0, '0, '0);
        wait_idle();

        write_all(0, 1, 52'hF_FFFF_FFC0_0000, 52'hF_FFFF_8000_0000);
        send_request(FN_RESERVE, 0, 11'd3, '0);
        send_request(FN_FREE, 1, '0, 52'hF_FFFF_8000_0000);
        wait_idle();

        write_all(1, 1, 52'h123, 52'h4000_0000);
        send_request(FN_RESERVE, 0, 11'd3, '0);
        wait_idle();

        for (int n = 0; n < 450; n++) begin
            if (n % 75 == 0) begin
                wait_idle();
                write_all($urandom_range(99) < 85, $urandom_range(99) < 80,
                          rand_base(0), rand_base(1));
            end
            calm = (n >= 200 && n < 280);
            random_request();
        end
        calm = 0;

        wait_idle();
        repeat (40) @(negedge aclk);
        $display("Covered %0d reserve, %0d allocate, %0d free, %0d unknown requests under %0d settings.",
                 ledger.req_kind[FN_RESERVE], ledger.req_kind[FN_ALLOC],
                 ledger.req_kind[FN_FREE], ledger.req_kind[FN_UNKNOWN], settings);
        $display("Checked %0d replies; pools ended with %0d and %0d pages, %0d mismatches.",
                 ledger.replies_seen, ledger.entries[0], ledger.entries[1], ledger.errors);
        if (ledger.errors == 0 && ledger.replies_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
